[rtl/tlsp_pkg.sv]
// tlsp_pkg: shared types, codes and constants for the three-lane signal core
// no dependencies; imported by every rtl module and by the channel interfaces
package tlsp_pkg;

	localparam int TIMER_BITS   = 16;
	localparam int DUR_BITS     = 16;
	localparam int CMD_BITS     = 8;
	localparam int CFG_IDX_BITS = 2;
	localparam int LAMP_BITS    = 2;
	localparam int LANE_BITS    = 2;
	localparam int LANES        = 3;
	// timers and durations are compared at the wider of the two widths
	localparam int CMP_BITS     = (TIMER_BITS > DUR_BITS) ? TIMER_BITS : DUR_BITS;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	localparam logic [DUR_BITS-1:0] GREEN_RST   = DUR_BITS'(5000);
	localparam logic [DUR_BITS-1:0] YELLOW_RST  = DUR_BITS'(3000);
	localparam logic [DUR_BITS-1:0] TIMEOUT_RST = DUR_BITS'(3000);

	localparam logic [CMD_BITS-1:0] CMD_PREEMPT = CMD_BITS'(1);

	localparam logic [LANE_BITS-1:0] LANE_FIRST = LANE_BITS'(0);
	localparam logic [LANE_BITS-1:0] LANE_LAST  = LANE_BITS'(LANES - 1);

	typedef enum logic [LAMP_BITS-1:0] {
		LAMP_RED    = 2'd0,
		LAMP_YELLOW = 2'd1,
		LAMP_GREEN  = 2'd2
	} lamp_t;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_CMD  = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_GREEN   = 2'd0,
		CFG_YELLOW  = 2'd1,
		CFG_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [DUR_BITS-1:0] green_duration;
		logic [DUR_BITS-1:0] yellow_duration;
		logic [DUR_BITS-1:0] preempt_timeout;
	} cfg_t;

	typedef struct packed {
		logic                action;
		logic [CMD_BITS-1:0] command_byte;
	} item_t;

	typedef struct packed {
		lamp_t lane_one_lamp;
		lamp_t lane_two_lamp;
		lamp_t lane_three_lamp;
		logic  preempt_active;
	} res_t;

endpackage

[rtl/tlsp_if.sv]
// tlsp_in_if / tlsp_out_if: valid/ready channels for items and results
// depends on tlsp_pkg for payload widths
interface tlsp_in_if;
	import tlsp_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [CMD_BITS-1:0] command_byte;

	modport source (output valid, output action, output command_byte, input ready);
	modport sink   (input valid, input action, input command_byte, output ready);
endinterface

interface tlsp_out_if;
	import tlsp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [LAMP_BITS-1:0] lane_one_lamp;
	logic [LAMP_BITS-1:0] lane_two_lamp;
	logic [LAMP_BITS-1:0] lane_three_lamp;
	logic                 preempt_active;

	modport source (output valid, output lane_one_lamp, output lane_two_lamp,
		output lane_three_lamp, output preempt_active, input ready);
	modport sink   (input valid, input lane_one_lamp, input lane_two_lamp,
		input lane_three_lamp, input preempt_active, output ready);
endinterface

[rtl/tlsp_cfg.sv]
// tlsp_cfg: duration and timeout registers behind the plain write port
// depends on tlsp_pkg
module tlsp_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [tlsp_pkg::CFG_IDX_BITS-1:0] index,
	input  logic [tlsp_pkg::DUR_BITS-1:0] data,
	output tlsp_pkg::cfg_t                cfg
);
	import tlsp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.green_duration  <= GREEN_RST;
			cfg_q.yellow_duration <= YELLOW_RST;
			cfg_q.preempt_timeout <= TIMEOUT_RST;
		end else if (we) begin
			unique case (cfg_idx_t'(index))
				CFG_GREEN:   cfg_q.green_duration  <= data;
				CFG_YELLOW:  cfg_q.yellow_duration <= data;
				CFG_TIMEOUT: cfg_q.preempt_timeout <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[rtl/tlsp_seq.sv]
// tlsp_seq: lane sequencer state, preemption timer and lamp pattern update
// depends on tlsp_pkg; one beat is folded into the state per accept
module tlsp_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  tlsp_pkg::item_t item,
	input  tlsp_pkg::cfg_t  cfg,
	output tlsp_pkg::res_t  res_next
);
	import tlsp_pkg::*;

	logic                  flag_q, flag_n;
	logic [TIMER_BITS-1:0] pe_q, pe_n, pe_inc;
	logic [TIMER_BITS-1:0] ph_q, ph_n, ph_inc;
	logic [LANE_BITS-1:0]  lane_q, lane_n, lane_sel;
	logic                  yel_q, yel_n, yel_cur;
	lamp_t                 lamps_q [LANES];
	lamp_t                 lamps_n [LANES];
	lamp_t                 color;
	logic                  timed_out;

	assign pe_inc = (pe_q == TIMER_MAX) ? pe_q : pe_q + 1'b1;
	assign ph_inc = (ph_q == TIMER_MAX) ? ph_q : ph_q + 1'b1;
	assign timed_out = flag_q && (CMP_BITS'(pe_inc) > CMP_BITS'(cfg.preempt_timeout));

	always_comb begin
		flag_n   = flag_q;
		pe_n     = pe_q;
		ph_n     = ph_q;
		lane_n   = lane_q;
		yel_n    = yel_q;
		lamps_n  = lamps_q;
		yel_cur  = yel_q;
		lane_sel = (lane_q > LANE_LAST) ? LANE_LAST : lane_q;
		color    = LAMP_GREEN;
		if (action_t'(item.action) == ACT_TICK) begin
			pe_n = pe_inc;
			ph_n = ph_inc;
			if (timed_out) begin
				flag_n   = 1'b0;
				lane_sel = LANE_FIRST;
				yel_cur  = 1'b0;
				ph_n     = '0;
				lane_n   = LANE_FIRST;
				yel_n    = 1'b0;
			end
			if (flag_n) begin
				// preemption holds lane one green
				lamps_n[0] = LAMP_GREEN;
				for (int i = 1; i < LANES; i++) begin
					lamps_n[i] = LAMP_RED;
				end
			end else begin
				color = yel_cur ? LAMP_YELLOW : LAMP_GREEN;
				for (int i = 0; i < LANES; i++) begin
					lamps_n[i] = (lane_sel == LANE_BITS'(i)) ? color : LAMP_RED;
				end
				if (!yel_cur) begin
					if (CMP_BITS'(ph_n) >= CMP_BITS'(cfg.green_duration)) begin
						yel_n = 1'b1;
						ph_n  = '0;
					end
				end else if (CMP_BITS'(ph_n) >= CMP_BITS'(cfg.yellow_duration)) begin
					lane_n = (lane_sel == LANE_LAST) ? LANE_FIRST : lane_sel + 1'b1;
					yel_n  = 1'b0;
					ph_n   = '0;
				end
			end
		end else if (item.command_byte == CMD_PREEMPT) begin
			flag_n = 1'b1;
			pe_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			pe_q   <= '0;
			ph_q   <= '0;
			lane_q <= LANE_FIRST;
			yel_q  <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				lamps_q[i] <= LAMP_RED;
			end
		end else if (accept) begin
			flag_q  <= flag_n;
			pe_q    <= pe_n;
			ph_q    <= ph_n;
			lane_q  <= lane_n;
			yel_q   <= yel_n;
			lamps_q <= lamps_n;
		end
	end

	assign res_next.lane_one_lamp   = lamps_n[0];
	assign res_next.lane_two_lamp   = lamps_n[1];
	assign res_next.lane_three_lamp = lamps_n[2];
	assign res_next.preempt_active  = flag_n;
endmodule

[rtl/tlsp_outreg.sv]
// tlsp_outreg: result register between the sequencer and the result channel
// depends on tlsp_pkg; takes a new beat whenever empty or being drained
module tlsp_outreg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  tlsp_pkg::res_t  res_in,
	input  logic           out_ready,
	output logic           out_valid,
	output tlsp_pkg::res_t  res_out,
	output logic           can_load
);
	import tlsp_pkg::*;

	logic valid_q;
	res_t res_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;
endmodule

[rtl/three_lane_signal_with_preemption_core.sv]
// three_lane_signal_with_preemption_core: three-lane signal sequencer with preemption
// a result is valid in the cycle after its item is accepted; one item per cycle while
// results drain, set by the single state update between handshake and result register
// ready stays high while the result register is empty or being drained
// reset: all lamps red, lane one green phase next, no preemption, default durations
module three_lane_signal_with_preemption_core (
	input  logic                              clk,
	input  logic                              arst_n,
	tlsp_in_if.sink                           items,
	tlsp_out_if.source                        results,
	input  logic                              cfg_we,
	input  logic [tlsp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [tlsp_pkg::DUR_BITS-1:0]     cfg_data
);
	import tlsp_pkg::*;

	cfg_t  cfg;
	item_t item;
	res_t  res_next;
	res_t  res_out;
	logic  can_load;
	logic  accept;

	assign item.action       = items.action;
	assign item.command_byte = items.command_byte;
	assign items.ready       = can_load;
	assign accept            = items.valid && can_load;

	tlsp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tlsp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg),
		.res_next (res_next)
	);

	tlsp_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_in    (res_next),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.res_out   (res_out),
		.can_load  (can_load)
	);

	assign results.lane_one_lamp   = res_out.lane_one_lamp;
	assign results.lane_two_lamp   = res_out.lane_two_lamp;
	assign results.lane_three_lamp = res_out.lane_three_lamp;
	assign results.preempt_active  = res_out.preempt_active;

	// every accepted beat shows up as a result on the next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready |=> results.valid)
		else $error("accepted item did not produce a result");

	// a preemption command is reflected at once in its own result
	a_preempt_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && items.action == ACT_CMD
			&& items.command_byte == CMD_PREEMPT
		|=> results.valid && results.preempt_active)
		else $error("preemption command not reflected in result");

	// never more than one lane lit
	a_one_lane_lit: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |->
			!((results.lane_one_lamp != LAMP_RED && results.lane_two_lamp != LAMP_RED)
			|| (results.lane_one_lamp != LAMP_RED && results.lane_three_lamp != LAMP_RED)
			|| (results.lane_two_lamp != LAMP_RED && results.lane_three_lamp != LAMP_RED)))
		else $error("more than one lane lit");
endmodule
